// File: rtl/core/iirh_pkg.sv
// Shared types, constants and register map of the third-order high-pass filter.
`timescale 1ns / 1ps
package iirh_pkg;

  localparam int TAP_COUNT  = 4;
  localparam int NUM_COEF   = 2 * TAP_COUNT - 1;
  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 14;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int QUO_W      = ACC_W - COEF_FRAC;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [QUO_W-1:0]    quo_t;
  typedef logic [REG_IDX_W-1:0]       reg_idx_t;

  // Register map, word index into the configuration space.
  localparam reg_idx_t REG_FF_COEF_0 = 3'd0;
  localparam reg_idx_t REG_FF_COEF_1 = 3'd1;
  localparam reg_idx_t REG_FF_COEF_2 = 3'd2;
  localparam reg_idx_t REG_FF_COEF_3 = 3'd3;
  localparam reg_idx_t REG_FB_COEF_1 = 3'd4;
  localparam reg_idx_t REG_FB_COEF_2 = 3'd5;
  localparam reg_idx_t REG_FB_COEF_3 = 3'd6;

  localparam coef_t COEF_RESET [NUM_COEF] = '{
    18'sd14657, -18'sd43953, 18'sd43953, -18'sd14657,
    -18'sd45487, 18'sd42237, -18'sd13111
  };

  localparam quo_t Q_MAX = quo_t'(SAMPLE_MAX);
  localparam quo_t Q_MIN = quo_t'(SAMPLE_MIN);

  // Per-cell strobes: shift the tap line, load the product register.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: rtl/core/iirh_cell.sv
// One feed-forward cell: an input tap, its coefficient product and a partial-sum adder.
`timescale 1ns / 1ps
module iirh_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  iirh_pkg::cell_ctl_t ctl,
  input  iirh_pkg::coef_t    coef,
  input  iirh_pkg::sample_t  x_in,
  output iirh_pkg::sample_t  x_out,
  input  iirh_pkg::acc_t     psum_in,
  output iirh_pkg::acc_t     psum_out
);

  iirh_pkg::sample_t x_tap_r;
  iirh_pkg::prod_t   prod_r;
  iirh_pkg::prod_t   prod_nxt;

  assign prod_nxt = coef * x_tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_tap_r <= '0;
    end else if (ctl.shift) begin
      x_tap_r <= x_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= prod_nxt;
    end
  end

  assign x_out    = x_tap_r;
  assign psum_out = psum_in + iirh_pkg::acc_t'(prod_r);

endmodule

// File: rtl/core/iirh_fb.sv
// Feedback stage: output taps, feedback products, truncation and saturation.
`timescale 1ns / 1ps
module iirh_fb (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  iirh_pkg::coef_t   coef_a1,
  input  iirh_pkg::coef_t   coef_a2,
  input  iirh_pkg::coef_t   coef_a3,
  input  iirh_pkg::acc_t    ff_sum,
  output iirh_pkg::sample_t sample,
  output logic              clipped
);

  iirh_pkg::sample_t y0_r;
  iirh_pkg::sample_t y1_r;
  iirh_pkg::sample_t y2_r;
  iirh_pkg::prod_t   fbp2_r;
  iirh_pkg::prod_t   fbp3_r;
  logic              clipped_r;

  iirh_pkg::prod_t   m1;
  iirh_pkg::sample_t y1_nxt;
  iirh_pkg::sample_t y2_nxt;
  iirh_pkg::acc_t    acc;
  iirh_pkg::quo_t    quo;
  iirh_pkg::sample_t y_nxt;
  logic              clip_nxt;

  // Keep the older products in step with the taps they will see next cycle.
  assign y1_nxt = go ? y0_r : y1_r;
  assign y2_nxt = go ? y1_r : y2_r;

  assign m1  = coef_a1 * y0_r;
  assign acc = ff_sum - iirh_pkg::acc_t'(m1) - iirh_pkg::acc_t'(fbp2_r)
             - iirh_pkg::acc_t'(fbp3_r);

  always_comb begin
    // Floor shift, then step up by one for a negative sum with a remainder.
    quo = acc[iirh_pkg::ACC_W-1:iirh_pkg::COEF_FRAC]
        + iirh_pkg::quo_t'({1'b0, acc[iirh_pkg::ACC_W-1] & (|acc[iirh_pkg::COEF_FRAC-1:0])});
    if (quo > iirh_pkg::Q_MAX) begin
      y_nxt    = iirh_pkg::sample_t'(iirh_pkg::SAMPLE_MAX);
      clip_nxt = 1'b1;
    end else if (quo < iirh_pkg::Q_MIN) begin
      y_nxt    = iirh_pkg::sample_t'(iirh_pkg::SAMPLE_MIN);
      clip_nxt = 1'b1;
    end else begin
      y_nxt    = quo[iirh_pkg::SAMPLE_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y0_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (go) begin
      y0_r <= y_nxt;
      y1_r <= y0_r;
      y2_r <= y1_r;
    end
  end

  always_ff @(posedge clk) begin
    fbp2_r <= coef_a2 * y1_nxt;
    fbp3_r <= coef_a3 * y2_nxt;
    if (go) begin
      clipped_r <= clip_nxt;
    end
  end

  assign sample  = y0_r;
  assign clipped = clipped_r;

endmodule

// File: rtl/core/third_order_iir_highpass.sv
// Path: tap line, products, feed-forward sum, output register. Throughput: one
// sample per cycle while out_stall is low; the closing loop is the one-sample
// output feedback, one multiply by the first feedback coefficient, add, saturate.
// Reset (synchronous, rst_n low): sample history clears to zero, coefficients
// return to their defaults, pipeline and output empty. No clearing pass.
`timescale 1ns / 1ps
module third_order_iir_highpass (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_sample_out,
  output logic                                out_clipped,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [iirh_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [iirh_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [iirh_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int TAPS = iirh_pkg::TAP_COUNT;

  iirh_pkg::coef_t coef_r [iirh_pkg::NUM_COEF];

  logic v0_r, v1_r, v2_r, out_valid_r;
  logic accept, go1, go2, go_out, out_taken;

  iirh_pkg::acc_t      ff_sum_r;
  iirh_pkg::reg_idx_t  reg_idx;
  logic                cfg_wr;
  logic                reg_hit;
  iirh_pkg::cell_ctl_t cell_ctl;

  iirh_pkg::sample_t x_link    [TAPS];
  iirh_pkg::acc_t    psum_link [TAPS+1];

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[iirh_pkg::CFG_ADDR_W-1:2];
  assign reg_hit    = (reg_idx <= iirh_pkg::REG_FB_COEF_3);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iirh_pkg::NUM_COEF; i++) begin
        coef_r[i] <= iirh_pkg::COEF_RESET[i];
      end
    end else if (cfg_wr && reg_hit) begin
      coef_r[reg_idx] <= cfg_pwdata[iirh_pkg::COEF_W-1:0];
    end
  end

  always_comb begin
    if (reg_hit) begin
      cfg_prdata = iirh_pkg::CFG_DATA_W'(coef_r[reg_idx]);
    end else begin
      cfg_prdata = '0;
    end
  end

  // ---------------- pipeline control ----------------
  // Stages: tap line, products, feed-forward sum, output register.
  assign out_taken = out_valid_r && !out_stall;
  assign go_out    = v2_r && (!out_valid_r || !out_stall);
  assign go2       = v1_r && (!v2_r || go_out);
  assign go1       = v0_r && (!v1_r || go2);
  assign in_stall  = v0_r && !go1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        v0_r <= 1'b1;
      end else if (go1) begin
        v0_r <= 1'b0;
      end
      if (go1) begin
        v1_r <= 1'b1;
      end else if (go2) begin
        v1_r <= 1'b0;
      end
      if (go2) begin
        v2_r <= 1'b1;
      end else if (go_out) begin
        v2_r <= 1'b0;
      end
      if (go_out) begin
        out_valid_r <= 1'b1;
      end else if (out_taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- feed-forward cell chain ----------------
  assign cell_ctl.shift = accept;
  assign cell_ctl.load  = go1;
  assign psum_link[0]   = '0;
  assign x_link[0]      = in_sample_in;

  for (genvar t = 0; t < TAPS; t++) begin : g_cell
    if (t < TAPS - 1) begin : g_mid
      iirh_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .coef     (coef_r[t]),
        .x_in     (x_link[t]),
        .x_out    (x_link[t+1]),
        .psum_in  (psum_link[t]),
        .psum_out (psum_link[t+1])
      );
    end else begin : g_last
      iirh_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .coef     (coef_r[t]),
        .x_in     (x_link[t]),
        .x_out    (),
        .psum_in  (psum_link[t]),
        .psum_out (psum_link[t+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      ff_sum_r <= psum_link[TAPS];
    end
  end

  // ---------------- feedback and output ----------------
  iirh_fb u_fb (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_out),
    .coef_a1 (coef_r[iirh_pkg::REG_FB_COEF_1]),
    .coef_a2 (coef_r[iirh_pkg::REG_FB_COEF_2]),
    .coef_a3 (coef_r[iirh_pkg::REG_FB_COEF_3]),
    .ff_sum  (ff_sum_r),
    .sample  (out_sample_out),
    .clipped (out_clipped)
  );

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  a_accept_fills_taps : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v0_r)
    else $error("accepted transaction did not occupy the tap stage");

  a_clip_at_rail : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_sample_out == 16'sh7fff || out_sample_out == 16'sh8000))
    else $error("clipped flag set on an unsaturated sample");

  a_sum_held : assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !go_out) |=> (v2_r && $stable(ff_sum_r)))
    else $error("feed-forward sum lost while output blocked");

  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (out_taken && !go_out) |=> !out_valid)
    else $error("output transaction repeated after hand-off");

endmodule
